### hdl/swsend_pkg.sv
// ----------------------------------------------------------------------------
// swsend_pkg: shared types and codes of the sliding-window sender
// Item kinds, timer commands, acknowledgment status codes, controller state
// encoding and the command group from controller to datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swsend_pkg;

  // Item kinds on in_kind.
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Timer commands on out_timer_command.
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  // Acknowledgment status codes on out_ack_status.
  localparam logic [2:0] ACK_NONE      = 3'd0;
  localparam logic [2:0] ACK_NEW       = 3'd1;
  localparam logic [2:0] ACK_BAD_CKSUM = 3'd2;
  localparam logic [2:0] ACK_DUP       = 3'd3;
  localparam logic [2:0] ACK_DUP_FAST  = 3'd4;

  // Duplicate counter and threshold register.
  localparam int          DUP_BITS      = 4;
  localparam logic [3:0]  DUP_MAX       = 4'd15;
  localparam logic [3:0]  DUP_THR_RESET = 4'd3;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;  // latch the input item and read the base payload
    logic commit;   // update window state and register the result
  } cmd_t;

endpackage

`default_nettype wire

### hdl/swsend_ctrl.sv
// ----------------------------------------------------------------------------
// swsend_ctrl: sequencer of the sliding-window sender
// Two-state machine that takes an item in the idle state and commits it in the
// next cycle, in the execute state, driving busy and the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module swsend_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output swsend_pkg::cmd_t       cmd
);

  swsend_pkg::state_t state_r;
  swsend_pkg::state_t state_nxt;

  // Next state: an execute state after every accepted item, then back to idle.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swsend_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = swsend_pkg::ST_EXEC;
        end
      end
      swsend_pkg::ST_EXEC: begin
        state_nxt = swsend_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = swsend_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swsend_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands and handshake status.
  assign busy        = (state_r == swsend_pkg::ST_EXEC);
  assign cmd.capture = start && (state_r == swsend_pkg::ST_IDLE);
  assign cmd.commit  = (state_r == swsend_pkg::ST_EXEC);

endmodule

`default_nettype wire

### hdl/swsend_dp.sv
// ----------------------------------------------------------------------------
// swsend_dp: datapath of the sliding-window sender
// Window pointers, sequence counter, duplicate counter, payload ring memory
// and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module swsend_dp #(
  parameter int SEQ_BITS     = 3,
  parameter int WINDOW_SLOTS = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire swsend_pkg::cmd_t        cmd,
  input  wire logic [1:0]              in_kind,
  input  wire logic [PAYLOAD_BITS-1:0] in_send_payload,
  input  wire logic [SEQ_BITS-1:0]     in_ack_number,
  input  wire logic                    in_ack_checksum_ok,
  input  wire logic [SEQ_BITS-1:0]     in_expired_seq,
  input  wire logic                    cfg_we,
  input  wire logic [3:0]              cfg_wdata,
  output logic                         out_valid,
  output logic                         out_send_accepted,
  output logic                         out_packet_valid,
  output logic [SEQ_BITS-1:0]          out_packet_seq,
  output logic [PAYLOAD_BITS-1:0]      out_packet_payload,
  output logic [1:0]                   out_timer_command,
  output logic [SEQ_BITS-1:0]          out_timer_seq,
  output logic [2:0]                   out_ack_status,
  output logic                         out_window_full
);

  localparam int SB = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int AW = ((SEQ_BITS > SB) ? SEQ_BITS : SB) + 2;
  localparam logic [AW-1:0] W_A    = AW'(WINDOW_SLOTS);
  localparam logic [AW-1:0] WM1_A  = AW'(WINDOW_SLOTS - 1);

  // Window state.
  logic [SEQ_BITS-1:0] next_seq_r, next_seq_nxt;
  logic [SB-1:0]       base_r, base_nxt;
  logic [SB-1:0]       end_r, end_nxt;
  logic                full_r, full_nxt;
  logic [3:0]          dup_r, dup_nxt;
  logic [3:0]          thr_r;

  // Captured item and base payload read.
  logic [1:0]              kind_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [SEQ_BITS-1:0]     ack_r;
  logic                    ck_r;
  logic [SEQ_BITS-1:0]     exp_r;
  logic [PAYLOAD_BITS-1:0] rd_r;

  logic [PAYLOAD_BITS-1:0] mem [WINDOW_SLOTS];

  // Result before its output register.
  logic                    acc_nxt, pv_nxt;
  logic [SEQ_BITS-1:0]     pseq_nxt, tseq_nxt;
  logic [PAYLOAD_BITS-1:0] ppay_nxt;
  logic [1:0]              tcmd_nxt;
  logic [2:0]              stat_nxt;
  logic                    mem_we;

  logic                    out_valid_r;
  logic                    acc_r, pv_r, full_out_r;
  logic [SEQ_BITS-1:0]     pseq_r, tseq_r;
  logic [PAYLOAD_BITS-1:0] ppay_r;
  logic [1:0]              tcmd_r;
  logic [2:0]              stat_r;

  // Derived window quantities.
  logic [AW-1:0]       occ;
  logic [AW-1:0]       occ_after;
  logic [AW-1:0]       seq_diff;
  logic [SEQ_BITS-1:0] base_seq;
  logic [SEQ_BITS-1:0] off;
  logic                in_win;
  logic [AW-1:0]       nb_sum;
  logic [AW-1:0]       end_inc;
  logic [3:0]          dup_inc;

  // Occupancy, sequence number at the base and acknowledgment offset.
  always_comb begin
    if (end_r >= base_r) begin
      occ = AW'(end_r) - AW'(base_r);
    end else begin
      occ = AW'(end_r) + W_A - AW'(base_r);
    end
    seq_diff = AW'(next_seq_r) - occ;
    base_seq = seq_diff[SEQ_BITS-1:0];
    off      = ack_r - base_seq;
    in_win   = AW'(off) < occ;
    nb_sum   = AW'(base_r) + AW'(off) + AW'(1);
    if (nb_sum >= W_A) begin
      nb_sum = nb_sum - W_A;
    end
    end_inc = AW'(end_r) + AW'(1);
    if (end_inc == W_A) begin
      end_inc = '0;
    end
    dup_inc = (dup_r == swsend_pkg::DUP_MAX) ? dup_r : dup_r + 4'd1;
  end

  // Item execution.
  always_comb begin
    next_seq_nxt = next_seq_r;
    base_nxt     = base_r;
    end_nxt      = end_r;
    dup_nxt      = dup_r;
    occ_after    = occ;
    mem_we       = 1'b0;
    acc_nxt      = 1'b0;
    pv_nxt       = 1'b0;
    pseq_nxt     = '0;
    ppay_nxt     = '0;
    tcmd_nxt     = swsend_pkg::TMR_NONE;
    tseq_nxt     = '0;
    stat_nxt     = swsend_pkg::ACK_NONE;
    unique case (kind_r)
      swsend_pkg::KIND_SEND: begin
        if (!full_r) begin
          mem_we       = 1'b1;
          acc_nxt      = 1'b1;
          pv_nxt       = 1'b1;
          pseq_nxt     = next_seq_r;
          ppay_nxt     = pay_r;
          if (occ == '0) begin
            tcmd_nxt = swsend_pkg::TMR_START;
            tseq_nxt = next_seq_r;
          end
          next_seq_nxt = next_seq_r + SEQ_BITS'(1);
          end_nxt      = end_inc[SB-1:0];
          occ_after    = occ + AW'(1);
        end
      end
      swsend_pkg::KIND_ACK: begin
        if (occ != '0) begin
          if (ck_r && in_win) begin
            base_nxt  = nb_sum[SB-1:0];
            dup_nxt   = '0;
            stat_nxt  = swsend_pkg::ACK_NEW;
            occ_after = occ - AW'(off) - AW'(1);
            if (occ_after != '0) begin
              tcmd_nxt = swsend_pkg::TMR_RESTART;
              tseq_nxt = base_seq + off + SEQ_BITS'(1);
            end else begin
              tcmd_nxt = swsend_pkg::TMR_STOP;
            end
          end else if (!ck_r) begin
            stat_nxt = swsend_pkg::ACK_BAD_CKSUM;
          end else if (dup_inc >= thr_r) begin
            // Enough duplicates: resend the window base.
            dup_nxt  = '0;
            stat_nxt = swsend_pkg::ACK_DUP_FAST;
            pv_nxt   = 1'b1;
            pseq_nxt = base_seq;
            ppay_nxt = rd_r;
          end else begin
            dup_nxt  = dup_inc;
            stat_nxt = swsend_pkg::ACK_DUP;
          end
        end
      end
      swsend_pkg::KIND_TIMEOUT: begin
        if (occ != '0) begin
          tcmd_nxt = swsend_pkg::TMR_RESTART;
          tseq_nxt = exp_r;
          pv_nxt   = 1'b1;
          pseq_nxt = base_seq;
          ppay_nxt = rd_r;
        end
      end
      default: begin
        // Unused kind: no effect.
      end
    endcase
    full_nxt = (occ_after == WM1_A);
  end

  // Control state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r  <= '0;
      base_r      <= '0;
      end_r       <= '0;
      full_r      <= 1'b0;
      dup_r       <= '0;
      thr_r       <= swsend_pkg::DUP_THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        next_seq_r <= next_seq_nxt;
        base_r     <= base_nxt;
        end_r      <= end_nxt;
        full_r     <= full_nxt;
        dup_r      <= dup_nxt;
      end
    end
  end

  // Item capture, payload ring memory and result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      pay_r  <= in_send_payload;
      ack_r  <= in_ack_number;
      ck_r   <= in_ack_checksum_ok;
      exp_r  <= in_expired_seq;
      rd_r   <= mem[base_r];
    end
    if (cmd.commit && mem_we) begin
      mem[end_r] <= pay_r;
    end
    if (cmd.commit) begin
      acc_r      <= acc_nxt;
      pv_r       <= pv_nxt;
      pseq_r     <= pseq_nxt;
      ppay_r     <= ppay_nxt;
      tcmd_r     <= tcmd_nxt;
      tseq_r     <= tseq_nxt;
      stat_r     <= stat_nxt;
      full_out_r <= full_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_send_accepted  = acc_r;
  assign out_packet_valid   = pv_r;
  assign out_packet_seq     = pseq_r;
  assign out_packet_payload = ppay_r;
  assign out_timer_command  = tcmd_r;
  assign out_timer_seq      = tseq_r;
  assign out_ack_status     = stat_r;
  assign out_window_full    = full_out_r;

endmodule

`default_nettype wire

### hdl/sliding_window_sender.sv
// ----------------------------------------------------------------------------
// sliding_window_sender: go-back-N sender with fast retransmit
// Keeps a ring of unacknowledged packets, emits new and resent packets,
// issues timer commands and reports acknowledgment status.
//
//   Channel   Handshake          Payload
//   input     start / busy       in_kind, in_send_payload, in_ack_number,
//                                in_ack_checksum_ok, in_expired_seq
//   result    out_valid strobe   out_send_accepted .. out_window_full
//   config    cfg_we             cfg_wdata (duplicate threshold)
//
// Every item is captured, together with a read of the base payload from
// the registered ring memory port, and is then committed to the window state.
// The result transfer is on the ports for one cycle after that; busy is low
// in that cycle, so the next item may be taken at its end.
// Reset clears the pointers and counters and sets the threshold to 3; the
// ring memory is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender #(
  parameter int SEQ_BITS     = 3,
  parameter int WINDOW_SLOTS = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_kind,
  input  wire logic [PAYLOAD_BITS-1:0] in_send_payload,
  input  wire logic [SEQ_BITS-1:0]     in_ack_number,
  input  wire logic                    in_ack_checksum_ok,
  input  wire logic [SEQ_BITS-1:0]     in_expired_seq,
  output logic                         out_valid,
  output logic                         out_send_accepted,
  output logic                         out_packet_valid,
  output logic [SEQ_BITS-1:0]          out_packet_seq,
  output logic [PAYLOAD_BITS-1:0]      out_packet_payload,
  output logic [1:0]                   out_timer_command,
  output logic [SEQ_BITS-1:0]          out_timer_seq,
  output logic [2:0]                   out_ack_status,
  output logic                         out_window_full,
  input  wire logic                    cfg_we,
  input  wire logic [3:0]              cfg_wdata
);

  swsend_pkg::cmd_t cmd;

  // Sequencer.
  swsend_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Window datapath.
  swsend_dp #(
    .SEQ_BITS     (SEQ_BITS),
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_kind            (in_kind),
    .in_send_payload    (in_send_payload),
    .in_ack_number      (in_ack_number),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .in_expired_seq     (in_expired_seq),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_send_accepted  (out_send_accepted),
    .out_packet_valid   (out_packet_valid),
    .out_packet_seq     (out_packet_seq),
    .out_packet_payload (out_packet_payload),
    .out_timer_command  (out_timer_command),
    .out_timer_seq      (out_timer_seq),
    .out_ack_status     (out_ack_status),
    .out_window_full    (out_window_full)
  );

endmodule

`default_nettype wire

### hdl/swsend_checker.sv
// ----------------------------------------------------------------------------
// swsend_checker: port-level checks of the sliding-window sender
// Watches the handshake timing and the consistency of result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module swsend_checker #(
  parameter int SEQ_BITS     = 3,
  parameter int PAYLOAD_BITS = 64
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire logic                out_send_accepted,
  input wire logic                out_packet_valid,
  input wire logic [SEQ_BITS-1:0] out_packet_seq,
  input wire logic [1:0]          out_timer_command,
  input wire logic [SEQ_BITS-1:0] out_timer_seq
);

  // An accepted item makes the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  // Busy always falls again after the execute state.
  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // A result follows directly on the busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result transfer without a preceding execute cycle");

  // An accepted send always emits its packet.
  a_send_emits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_accepted |-> out_packet_valid)
    else $error("accepted send without an emitted packet");

  // A timer start comes only with a new packet and names its sequence.
  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_timer_command == swsend_pkg::TMR_START) |->
      out_send_accepted && (out_timer_seq == out_packet_seq))
    else $error("timer start does not match the emitted packet");

endmodule

bind sliding_window_sender swsend_checker #(
  .SEQ_BITS     (SEQ_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_swsend_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_send_accepted (out_send_accepted),
  .out_packet_valid  (out_packet_valid),
  .out_packet_seq    (out_packet_seq),
  .out_timer_command (out_timer_command),
  .out_timer_seq     (out_timer_seq)
);

`default_nettype wire
